@@ hw/rtl/decimal_seven_segment_scan_unit_defines.svh @@
// Assertion helpers used by the scan unit serializer RTL.
`ifndef DECIMAL_SEVEN_SEGMENT_SCAN_UNIT_DEFINES_SVH
`define DECIMAL_SEVEN_SEGMENT_SCAN_UNIT_DEFINES_SVH

// Property that must hold on every clock edge out of reset.
`define DSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dss_pkg.sv @@
package dss_pkg;

    localparam int VAL_W      = 27;
    localparam int SEG_W      = 7;
    localparam int SEL_W      = 8;
    localparam int POS_W      = 3;
    localparam int BCD_W      = 4;
    localparam int DIGITS_DEF = 8;
    localparam int CMP_W      = 32;

    function automatic int pow10(input int n);
        int p;
        p = 1;
        for (int i = 0; i < n; i++)
            p = p * 10;
        return p;
    endfunction

    // Active-high segment code, bit0 = a ... bit6 = g.
    function automatic logic [SEG_W-1:0] seg_code(input logic [BCD_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/dss_cell.sv @@
module dss_cell #(
    parameter int DIGITS = 8,
    parameter int POS    = 0
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     advance,
    input  logic                                     prev_valid,
    input  logic [dss_pkg::VAL_W-1:0]                prev_rem,
    input  logic [DIGITS-1:0][dss_pkg::BCD_W-1:0]    prev_digits,
    output logic                                     valid,
    output logic [dss_pkg::VAL_W-1:0]                rem,
    output logic [DIGITS-1:0][dss_pkg::BCD_W-1:0]    digits
);
    import dss_pkg::*;

    // Place value of the digit this cell extracts.
    localparam logic [CMP_W-1:0] WEIGHT = CMP_W'(pow10(DIGITS - 1 - POS));

    logic                              valid_reg;
    logic [VAL_W-1:0]                  rem_reg;
    logic [VAL_W-1:0]                  rem_next;
    logic [DIGITS-1:0][BCD_W-1:0]      digits_reg;
    logic [DIGITS-1:0][BCD_W-1:0]      digits_next;
    logic [BCD_W-1:0]                  digit;
    logic [CMP_W-1:0]                  sub;

    // Incoming remainder is below 10 * WEIGHT; pick the largest multiple that fits.
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int j = 1; j < 10; j++)
        begin
            if (CMP_W'(prev_rem) >= CMP_W'(j) * WEIGHT)
            begin
                digit = BCD_W'(j);
                sub   = CMP_W'(j) * WEIGHT;
            end
        end
        rem_next         = prev_rem - sub[VAL_W-1:0];
        digits_next      = prev_digits;
        digits_next[POS] = digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg    <= rem_next;
            digits_reg <= digits_next;
        end
    end

    assign valid  = valid_reg;
    assign rem    = rem_reg;
    assign digits = digits_reg;

endmodule

@@ hw/rtl/dss_serializer.sv @@
`include "decimal_seven_segment_scan_unit_defines.svh"

module dss_serializer #(
    parameter int DIGITS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     load_valid,
    input  logic [dss_pkg::VAL_W-1:0]                load_rem,
    input  logic [DIGITS-1:0][dss_pkg::BCD_W-1:0]    load_digits,
    output logic                                     load_ok,
    output logic                                     result_valid,
    input  logic                                     result_ready,
    output logic [dss_pkg::SEG_W-1:0]                segments,
    output logic [dss_pkg::SEL_W-1:0]                digit_select,
    output logic [dss_pkg::POS_W-1:0]                digit_position,
    output logic                                     last
);
    import dss_pkg::*;

    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

    logic                          busy_reg;
    logic                          busy_next;
    logic [POS_W-1:0]              pos_reg;
    logic [POS_W-1:0]              pos_next;
    logic [DIGITS-1:0][BCD_W-1:0]  digits_reg;
    logic                          is_last;
    logic                          load;

    assign is_last = (pos_reg == LAST_POS);
    // Next run may load while the final digit of this one is being taken.
    assign load_ok = !busy_reg || (result_ready && is_last);
    assign load    = load_valid && load_ok;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
        end
        else if (busy_reg && result_ready)
        begin
            if (is_last)
                busy_next = 1'b0;
            else
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            digits_reg <= load_digits;
    end

    assign result_valid   = busy_reg;
    assign segments       = seg_code(digits_reg[pos_reg[IDX_W-1:0]]);
    assign digit_select   = ~(SEL_W'(1) << pos_reg);
    assign digit_position = pos_reg;
    assign last           = is_last;

    `DSS_ASSERT_ALWAYS(a_rem_zero, !load_valid || (load_rem == '0), "remainder left after last cell")
    `DSS_ASSERT_ALWAYS(a_pos_range, !busy_reg || (pos_reg <= LAST_POS), "digit position past end")
    `DSS_ASSERT_ALWAYS(a_bcd_range, !busy_reg || (digits_reg[pos_reg[IDX_W-1:0]] <= 4'd9), "digit not decimal")
    `DSS_ASSERT_NEXT(a_step, busy_reg && result_ready && !is_last, busy_reg && (pos_reg == $past(pos_reg) + 3'd1), "digit position did not advance")
    `DSS_ASSERT_NEXT(a_restart, busy_reg && result_ready && is_last, !busy_reg || (pos_reg == '0), "new run not at first digit")

endmodule

@@ hw/rtl/decimal_seven_segment_scan_unit.sv @@
// Splits each accepted binary value (saturated to all nines above 10^DIGITS - 1) into DIGITS
// decimal digits and returns one transaction per digit, most significant first, with its
// seven-segment code, active-low digit select, position and a last flag. The value walks a
// row of DIGITS cells, one cell per cycle while the row advances, each peeling off one
// digit, and then loads into the serializer. Results leave one per cycle while result_ready
// is high, and each value gives DIGITS results, so the result channel sets the sustained rate;
// a new value is taken while the previous one's digits are still being delivered, and the
// whole cell row holds once its last cell is occupied and the serializer cannot load it.
module decimal_seven_segment_scan_unit #(
    parameter int DIGITS = dss_pkg::DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [dss_pkg::VAL_W-1:0]     value,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [dss_pkg::SEG_W-1:0]     segments,
    output logic [dss_pkg::SEL_W-1:0]     digit_select,
    output logic [dss_pkg::POS_W-1:0]     digit_position,
    output logic                          last
);
    import dss_pkg::*;

    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(pow10(DIGITS) - 1);

    logic                                    advance;
    logic                                    load_ok;
    logic [DIGITS:0]                         chain_valid;
    logic [DIGITS:0][VAL_W-1:0]              chain_rem;
    logic [DIGITS:0][DIGITS-1:0][BCD_W-1:0]  chain_digits;

    // Cell row moves as one; it holds only when its tail has nowhere to go.
    assign advance    = !chain_valid[DIGITS] || load_ok;
    assign item_ready = advance;

    assign chain_valid[0]  = item_valid;
    assign chain_rem[0]    = (CMP_W'(value) > LIMIT) ? LIMIT[VAL_W-1:0] : value;
    assign chain_digits[0] = '0;

    for (genvar k = 0; k < DIGITS; k++)
    begin : g_cell
        dss_cell #(
            .DIGITS (DIGITS),
            .POS    (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .prev_valid  (chain_valid[k]),
            .prev_rem    (chain_rem[k]),
            .prev_digits (chain_digits[k]),
            .valid       (chain_valid[k+1]),
            .rem         (chain_rem[k+1]),
            .digits      (chain_digits[k+1])
        );
    end

    dss_serializer #(
        .DIGITS (DIGITS)
    ) u_serializer (
        .clk            (clk),
        .rst_n          (rst_n),
        .load_valid     (chain_valid[DIGITS]),
        .load_rem       (chain_rem[DIGITS]),
        .load_digits    (chain_digits[DIGITS]),
        .load_ok        (load_ok),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .segments       (segments),
        .digit_select   (digit_select),
        .digit_position (digit_position),
        .last           (last)
    );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    import dss_pkg::*;

    localparam int N_DIG          = (DIGITS_DEF < 1) ? 1 : (DIGITS_DEF > 8) ? 8 : DIGITS_DEF;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 4 * N_DIG + 8;
    localparam int MAX_REPORTED   = 10;
    localparam logic [VAL_W-1:0] VALUE_MAX = '1;

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [SEL_W-1:0] digit_select;
        logic [POS_W-1:0] digit_position;
        logic             last;
    } digit_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid = 1'b0;
    logic             item_ready;
    logic [VAL_W-1:0] value = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    logic [SEG_W-1:0] segments;
    logic [SEL_W-1:0] digit_select;
    logic [POS_W-1:0] digit_position;
    logic             last;

    digit_result_t    expected_digits[$];
    logic [VAL_W-1:0] pending_values[$];
    digit_result_t    want;
    digit_result_t    got;

    int  items_queued   = 0;
    int  items_accepted = 0;
    int  mismatches     = 0;
    int  stall_cycles   = 0;
    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    bit  item_taken     = 1'b0;

    decimal_seven_segment_scan_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .value          (value),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .segments       (segments),
        .digit_select   (digit_select),
        .digit_position (digit_position),
        .last           (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [SEG_W-1:0] glyph(input int d);
        case (d)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            default: return 7'h6F;
        endcase
    endfunction

    // Saturate, then peel digits from the most significant place down.
    task automatic predict_digits(input logic [VAL_W-1:0] v);
        longint        shown;
        longint        place;
        longint        top;
        logic [SEL_W-1:0] sel;
        digit_result_t r;
        place = 1;
        for (int k = 1; k < N_DIG; k++)
            place = place * 10;
        top   = place * 10 - 1;
        shown = v;
        if (shown > top)
            shown = top;
        sel = 8'hFE;
        for (int k = 0; k < N_DIG; k++)
        begin
            r.segments       = glyph(int'((shown / place) % 10));
            r.digit_select   = sel;
            r.digit_position = POS_W'(k);
            r.last           = (k == N_DIG - 1);
            expected_digits.push_back(r);
            sel   = {sel[SEL_W-2:0], sel[SEL_W-1]};
            place = place / 10;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // Driver: new transaction only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            item_taken = 1'b0;
            if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item_valid <= 1'b1;
                value      <= pending_values.pop_front();
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: predict on input acceptance, check on result acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                predict_digits(value);
                items_accepted++;
                item_taken = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                got.segments       = segments;
                got.digit_select   = digit_select;
                got.digit_position = digit_position;
                got.last           = last;
                if (expected_digits.size() == 0)
                    note_mismatch($sformatf("unexpected result seg=%h sel=%h pos=%0d last=%b",
                        got.segments, got.digit_select, got.digit_position, got.last));
                else
                begin
                    want = expected_digits.pop_front();
                    if (got.segments !== want.segments
                        || got.digit_select !== want.digit_select
                        || got.digit_position !== want.digit_position
                        || got.last !== want.last)
                        note_mismatch($sformatf(
                            "exp seg=%h sel=%h pos=%0d last=%b, got seg=%h sel=%h pos=%0d last=%b",
                            want.segments, want.digit_select, want.digit_position, want.last,
                            got.segments, got.digit_select, got.digit_position, got.last));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("decimal_seven_segment_scan_unit: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic queue_value(input logic [VAL_W-1:0] v);
        pending_values.push_back(v);
        items_queued++;
    endtask

    // Mostly in-range values, plus saturating, raw full-width and short ones.
    function automatic logic [VAL_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return VAL_W'($urandom_range(0, 99999999));
        else if (pick == 6)
            return VAL_W'($urandom_range(100000000, 134217727));
        else if (pick == 7)
            return VAL_W'($urandom);
        else
            return VAL_W'($urandom_range(0, 999));
    endfunction

    task automatic wait_all_taken();
        while (items_accepted < items_queued)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        while (expected_digits.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 6;
        recv_idle_pct = 69;
        queue_value(0);
        queue_value(1);
        queue_value(9);
        queue_value(10);
        queue_value(99);
        queue_value(1234567);
        queue_value(9999999);
        queue_value(10000000);
        queue_value(12345678);
        queue_value(87654321);
        queue_value(98765432);
        queue_value(90909090);
        queue_value(80808080);
        queue_value(10203040);
        queue_value(56789012);
        queue_value(99999999);
        queue_value(100000000);     // just past the top, saturates
        queue_value(VALUE_MAX);
        queue_value(27'h5555555);
        queue_value(27'h2AAAAAA);
        for (int i = 0; i < 115; i++)
            queue_value(random_value());
        wait_all_taken();
        // hold the sender until every digit of the first batch is out
        wait_results_drained();

        send_idle_pct = 69;
        recv_idle_pct = 6;
        for (int i = 0; i < 115; i++)
            queue_value(random_value());
        wait_all_taken();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 110; i++)
            queue_value(random_value());
        wait_all_taken();
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_digits.size() == 0)
            $display("decimal_seven_segment_scan_unit: match");
        else
            $display("decimal_seven_segment_scan_unit: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/dss_pkg.sv
hw/rtl/dss_cell.sv
hw/rtl/dss_serializer.sv
hw/rtl/decimal_seven_segment_scan_unit.sv
sim/testbench.sv
